@@ rtl/pixel_colour_adjust_core_defines.svh @@
// ----------------------------------------------------------------------------
// Pixel colour adjust: assertion macros
// Shared macros for the concurrent checks on the pixel colour adjust core.
// ----------------------------------------------------------------------------
`ifndef PIXEL_COLOUR_ADJUST_CORE_DEFINES_SVH
`define PIXEL_COLOUR_ADJUST_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define PCA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high
`define PCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, live through reset
`define PCA_ASSERT_NEXT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pca_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel colour adjust: shared package
// Widths, hash and luma constants, mode and register codes, control types.
// ----------------------------------------------------------------------------
package pca_pkg;

   localparam int COORD_BITS = 12;
   localparam int STAGES     = 5;
   localparam int NUM_CH     = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // Datapath widths
   localparam int LUMA_W  = 20;
   localparam int LIN_W   = 26;
   localparam int DIFF_W  = 21;
   localparam int SPROD_W = 38;
   localparam int SVAL_W  = 40;
   localparam int NPROD_W = 29;
   localparam int NSUM_W  = 30;
   localparam int CLAMP_W = 42;

   // Grain hash multipliers
   localparam logic [31:0] HASH_KX = 32'd374761393;
   localparam logic [31:0] HASH_KY = 32'd668265263;
   localparam logic [31:0] HASH_KS = 32'd1274126177;

   // Rec.709 luma weights in Q12, summing to 4096
   localparam logic [11:0] LUMA_R = 12'd871;
   localparam logic [11:0] LUMA_G = 12'd2929;
   localparam logic [11:0] LUMA_B = 12'd296;

   localparam logic [15:0] GAIN_RESET = 16'd4096;
   localparam logic signed [LIN_W-1:0] CONTRAST_PIVOT = 26'sd524288;

   typedef enum logic [2:0] {
      MODE_BRIGHTNESS = 3'd0,
      MODE_CONTRAST   = 3'd1,
      MODE_SATURATION = 3'd2,
      MODE_EXPOSURE   = 3'd3,
      MODE_BALANCE    = 3'd4,
      MODE_NOISE      = 3'd5
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE         = 4'd0,
      CSR_ENABLE       = 4'd1,
      CSR_GAIN         = 4'd2,
      CSR_OFFSET_RED   = 4'd3,
      CSR_OFFSET_GREEN = 4'd4,
      CSR_OFFSET_BLUE  = 4'd5,
      CSR_NOISE_AMP    = 4'd6,
      CSR_NOISE_MONO   = 4'd7
   } csr_index_type;

   typedef struct packed {
      mode_type    mode;
      logic        enable;
      logic [15:0] gain;
      logic [12:0] offset_red;
      logic [12:0] offset_green;
      logic [12:0] offset_blue;
      logic [11:0] noise_amp;
      logic        noise_mono;
   } cfg_type;

   // adv[k] loads stage k+1
   typedef struct packed {
      logic [STAGES-1:0] adv;
   } pipe_ctrl_type;

   // Clamp an already shifted value to 0..255
   function automatic logic [7:0] sat_u8(input logic signed [CLAMP_W-1:0] v);
      logic [7:0] r;
      if (v[CLAMP_W-1]) begin
         r = 8'd0;
      end else if (|v[CLAMP_W-2:8]) begin
         r = 8'hff;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/pca_hash.sv @@
// ----------------------------------------------------------------------------
// Pixel colour adjust: grain hash pipeline
// Three-stage coordinate hash, one lane per colour salt, moving in step with
// the colour pipeline.
// ----------------------------------------------------------------------------
module pca_hash (
   input  logic                           clock,
   input  pca_pkg::pipe_ctrl_type         ctrl,
   input  logic [pca_pkg::COORD_BITS-1:0] pixel_x,
   input  logic [pca_pkg::COORD_BITS-1:0] pixel_y,
   input  logic                           noise_mono,
   output logic [31:0]                    hash_mix [pca_pkg::NUM_CH]
);

   localparam logic [31:0] SALT_TERM [pca_pkg::NUM_CH] = '{
      pca_pkg::HASH_KS,
      32'(pca_pkg::HASH_KS * 32'd2),
      32'(pca_pkg::HASH_KS * 32'd3)
   };

   logic [31:0] mx_ff, my_ff, mx_in, my_in;
   logic [31:0] n1_ff [pca_pkg::NUM_CH];
   logic [31:0] n1_in [pca_pkg::NUM_CH];
   logic [31:0] n2_ff [pca_pkg::NUM_CH];
   logic [31:0] n2_in [pca_pkg::NUM_CH];

   // Stage 1: coordinate products
   assign mx_in = 32'(32'(pixel_x) * pca_pkg::HASH_KX);
   assign my_in = 32'(32'(pixel_y) * pca_pkg::HASH_KY);

   // Stage 2: add salt and fold the top bits down
   always_comb begin
      logic [31:0] n0;
      for (int k = 0; k < pca_pkg::NUM_CH; k++) begin
         n0 = mx_ff + my_ff + (noise_mono ? SALT_TERM[0] : SALT_TERM[k]);
         n1_in[k] = n0 ^ (n0 >> 13);
      end
   end

   // Stage 3: final scramble multiply
   always_comb begin
      for (int k = 0; k < pca_pkg::NUM_CH; k++) begin
         n2_in[k] = 32'(n1_ff[k] * pca_pkg::HASH_KS);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
      end
      if (ctrl.adv[1]) begin
         n1_ff <= n1_in;
      end
      if (ctrl.adv[2]) begin
         n2_ff <= n2_in;
      end
   end

   assign hash_mix = n2_ff;

endmodule

@@ rtl/pca_colour.sv @@
// ----------------------------------------------------------------------------
// Pixel colour adjust: colour datapath
// Five-stage per-channel arithmetic for all modes, final clamp and the
// output register.
// ----------------------------------------------------------------------------
module pca_colour (
   input  logic                   clock,
   input  pca_pkg::pipe_ctrl_type ctrl,
   input  pca_pkg::cfg_type       cfg,
   input  logic [7:0]             red_in,
   input  logic [7:0]             green_in,
   input  logic [7:0]             blue_in,
   input  logic [7:0]             alpha_in,
   input  logic [31:0]            hash_mix [pca_pkg::NUM_CH],
   output logic [7:0]             red_out,
   output logic [7:0]             green_out,
   output logic [7:0]             blue_out,
   output logic [7:0]             alpha_out
);

   localparam int NC = pca_pkg::NUM_CH;

   logic [7:0]                          ch_in [NC];
   logic [pca_pkg::LUMA_W-1:0]          luma_in;

   // Stage 1
   logic [7:0]                          ch_s1_ff [NC];
   logic [7:0]                          alpha_s1_ff;
   logic [pca_pkg::LUMA_W-1:0]          luma_s1_ff;
   // Stage 2
   logic [7:0]                          ch_s2_ff [NC];
   logic [7:0]                          alpha_s2_ff;
   logic [pca_pkg::LUMA_W-1:0]          luma_s2_ff;
   logic signed [pca_pkg::LIN_W-1:0]    lin_s2_ff [NC];
   logic signed [pca_pkg::LIN_W-1:0]    lin_s2_in [NC];
   logic signed [pca_pkg::DIFF_W-1:0]   diff_s2_ff [NC];
   logic signed [pca_pkg::DIFF_W-1:0]   diff_s2_in [NC];
   // Stage 3
   logic [7:0]                          ch_s3_ff [NC];
   logic [7:0]                          alpha_s3_ff;
   logic [pca_pkg::LUMA_W-1:0]          luma_s3_ff;
   logic signed [pca_pkg::LIN_W-1:0]    lin_s3_ff [NC];
   logic signed [pca_pkg::SPROD_W-1:0]  sprod_s3_ff [NC];
   logic signed [pca_pkg::SPROD_W-1:0]  sprod_s3_in [NC];
   // Stage 4
   logic [7:0]                          ch_s4_ff [NC];
   logic [7:0]                          alpha_s4_ff;
   logic signed [pca_pkg::LIN_W-1:0]    lin_s4_ff [NC];
   logic signed [pca_pkg::SVAL_W-1:0]   sval_s4_ff [NC];
   logic signed [pca_pkg::SVAL_W-1:0]   sval_s4_in [NC];
   logic signed [pca_pkg::NPROD_W-1:0]  nprod_s4_ff [NC];
   logic signed [pca_pkg::NPROD_W-1:0]  nprod_s4_in [NC];
   // Stage 5: output register
   logic [7:0]                          res_ff [NC];
   logic [7:0]                          res_in [NC];
   logic [7:0]                          alpha_out_ff;

   assign ch_in[0] = red_in;
   assign ch_in[1] = green_in;
   assign ch_in[2] = blue_in;

   // Stage 1: luma from the three channels
   assign luma_in = pca_pkg::LUMA_W'(ch_in[0]) * pca_pkg::LUMA_W'(pca_pkg::LUMA_R)
                  + pca_pkg::LUMA_W'(ch_in[1]) * pca_pkg::LUMA_W'(pca_pkg::LUMA_G)
                  + pca_pkg::LUMA_W'(ch_in[2]) * pca_pkg::LUMA_W'(pca_pkg::LUMA_B);

   // Stage 2: offset, contrast and exposure terms; distance from luma
   always_comb begin
      logic [12:0]                      off;
      logic signed [8:0]                centred;
      logic signed [pca_pkg::LIN_W-1:0] cprod;
      logic [23:0]                      eprod;
      for (int i = 0; i < NC; i++) begin
         off = cfg.offset_red;
         if (cfg.mode == pca_pkg::MODE_BALANCE) begin
            if (i == 1) begin
               off = cfg.offset_green;
            end else if (i == 2) begin
               off = cfg.offset_blue;
            end
         end
         centred = $signed({1'b0, ch_s1_ff[i]}) - 9'sd128;
         cprod   = centred * $signed({1'b0, cfg.gain});
         eprod   = 24'(ch_s1_ff[i]) * 24'(cfg.gain);
         case (cfg.mode)
            pca_pkg::MODE_BRIGHTNESS, pca_pkg::MODE_BALANCE: begin
               lin_s2_in[i] = $signed({14'd0, ch_s1_ff[i], 4'd0})
                            + pca_pkg::LIN_W'($signed(off));
            end
            pca_pkg::MODE_CONTRAST: begin
               lin_s2_in[i] = pca_pkg::CONTRAST_PIVOT + cprod;
            end
            pca_pkg::MODE_EXPOSURE: begin
               lin_s2_in[i] = $signed({2'd0, eprod});
            end
            default: begin
               lin_s2_in[i] = '0;
            end
         endcase
         diff_s2_in[i] = $signed({1'b0, ch_s1_ff[i], 12'd0}) - $signed({1'b0, luma_s1_ff});
      end
   end

   // Stage 3: saturation gain product
   always_comb begin
      for (int i = 0; i < NC; i++) begin
         sprod_s3_in[i] = diff_s2_ff[i] * $signed({1'b0, cfg.gain});
      end
   end

   // Stage 4: saturation sum and grain product
   always_comb begin
      logic [15:0]        h;
      logic signed [15:0] hc;
      for (int i = 0; i < NC; i++) begin
         sval_s4_in[i] = $signed({8'd0, luma_s3_ff, 12'd0})
                       + pca_pkg::SVAL_W'(sprod_s3_ff[i]);
         h  = hash_mix[i][15:0] ^ hash_mix[i][31:16];
         hc = $signed({~h[15], h[14:0]});
         nprod_s4_in[i] = hc * $signed({1'b0, cfg.noise_amp});
      end
   end

   // Stage 5: select by mode, shift and clamp
   always_comb begin
      logic signed [pca_pkg::NSUM_W-1:0]  nsum;
      logic signed [pca_pkg::CLAMP_W-1:0] v;
      for (int i = 0; i < NC; i++) begin
         nsum = $signed({2'd0, ch_s4_ff[i], 20'd0}) + pca_pkg::NSUM_W'(nprod_s4_ff[i]);
         v    = '0;
         res_in[i] = ch_s4_ff[i];
         if (cfg.enable) begin
            case (cfg.mode)
               pca_pkg::MODE_BRIGHTNESS, pca_pkg::MODE_BALANCE: begin
                  v = pca_pkg::CLAMP_W'(lin_s4_ff[i] >>> 4);
                  res_in[i] = pca_pkg::sat_u8(v);
               end
               pca_pkg::MODE_CONTRAST, pca_pkg::MODE_EXPOSURE: begin
                  v = pca_pkg::CLAMP_W'(lin_s4_ff[i] >>> 12);
                  res_in[i] = pca_pkg::sat_u8(v);
               end
               pca_pkg::MODE_SATURATION: begin
                  v = pca_pkg::CLAMP_W'(sval_s4_ff[i] >>> 24);
                  res_in[i] = pca_pkg::sat_u8(v);
               end
               pca_pkg::MODE_NOISE: begin
                  v = pca_pkg::CLAMP_W'(nsum >>> 20);
                  res_in[i] = pca_pkg::sat_u8(v);
               end
               default: begin
                  res_in[i] = ch_s4_ff[i];
               end
            endcase
         end
      end
   end

   // Advance each stage when its load is allowed
   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         ch_s1_ff    <= ch_in;
         alpha_s1_ff <= alpha_in;
         luma_s1_ff  <= luma_in;
      end
      if (ctrl.adv[1]) begin
         ch_s2_ff    <= ch_s1_ff;
         alpha_s2_ff <= alpha_s1_ff;
         luma_s2_ff  <= luma_s1_ff;
         lin_s2_ff   <= lin_s2_in;
         diff_s2_ff  <= diff_s2_in;
      end
      if (ctrl.adv[2]) begin
         ch_s3_ff    <= ch_s2_ff;
         alpha_s3_ff <= alpha_s2_ff;
         luma_s3_ff  <= luma_s2_ff;
         lin_s3_ff   <= lin_s2_ff;
         sprod_s3_ff <= sprod_s3_in;
      end
      if (ctrl.adv[3]) begin
         ch_s4_ff    <= ch_s3_ff;
         alpha_s4_ff <= alpha_s3_ff;
         lin_s4_ff   <= lin_s3_ff;
         sval_s4_ff  <= sval_s4_in;
         nprod_s4_ff <= nprod_s4_in;
      end
      if (ctrl.adv[4]) begin
         res_ff       <= res_in;
         alpha_out_ff <= alpha_s4_ff;
      end
   end

   assign red_out   = res_ff[0];
   assign green_out = res_ff[1];
   assign blue_out  = res_ff[2];
   assign alpha_out = alpha_out_ff;

endmodule

@@ rtl/pixel_colour_adjust_core.sv @@
// Flow: each accepted req beat passes the stage registers 1 to 5 in order.
// Throughput: one pixel per cycle while the output is not stalled; the
// five-stage datapath lets empty stages close up while the output is stalled.
// Reset: synchronous, active high; clears all stage valid bits and loads the
// register defaults (mode brightness, disabled, gain 1.0, mono grain).
// ----------------------------------------------------------------------------
// Pixel colour adjust core
// Per-pixel RGBA brightness, contrast, saturation, exposure, colour balance
// and grain, with register file and pipeline flow control.
// ----------------------------------------------------------------------------
module pixel_colour_adjust_core (
   input  logic                           clock,
   input  logic                           reset,
   // Pixel in
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_red_in,
   input  logic [7:0]                     req_green_in,
   input  logic [7:0]                     req_blue_in,
   input  logic [7:0]                     req_alpha_in,
   input  logic [pca_pkg::COORD_BITS-1:0] req_pixel_x,
   input  logic [pca_pkg::COORD_BITS-1:0] req_pixel_y,
   // Pixel out
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_red_out,
   output logic [7:0]                     rsp_green_out,
   output logic [7:0]                     rsp_blue_out,
   output logic [7:0]                     rsp_alpha_out,
   // Register writes
   input  logic                           csr_write_en,
   input  logic [pca_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pca_pkg::CSR_DATA_W-1:0] csr_wdata
);

   pca_pkg::cfg_type              cfg_ff;
   logic [pca_pkg::STAGES-1:0]    valid_ff;
   logic [pca_pkg::STAGES-1:0]    valid_in;
   logic [pca_pkg::STAGES-1:0]    adv;
   pca_pkg::pipe_ctrl_type        ctrl;
   logic [31:0]                   hash_mix [pca_pkg::NUM_CH];

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= pca_pkg::MODE_BRIGHTNESS;
         cfg_ff.enable       <= 1'b0;
         cfg_ff.gain         <= pca_pkg::GAIN_RESET;
         cfg_ff.offset_red   <= '0;
         cfg_ff.offset_green <= '0;
         cfg_ff.offset_blue  <= '0;
         cfg_ff.noise_amp    <= '0;
         cfg_ff.noise_mono   <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            pca_pkg::CSR_MODE:         cfg_ff.mode <= pca_pkg::mode_type'(csr_wdata[2:0]);
            pca_pkg::CSR_ENABLE:       cfg_ff.enable       <= csr_wdata[0];
            pca_pkg::CSR_GAIN:         cfg_ff.gain         <= csr_wdata[15:0];
            pca_pkg::CSR_OFFSET_RED:   cfg_ff.offset_red   <= csr_wdata[12:0];
            pca_pkg::CSR_OFFSET_GREEN: cfg_ff.offset_green <= csr_wdata[12:0];
            pca_pkg::CSR_OFFSET_BLUE:  cfg_ff.offset_blue  <= csr_wdata[12:0];
            pca_pkg::CSR_NOISE_AMP:    cfg_ff.noise_amp    <= csr_wdata[11:0];
            pca_pkg::CSR_NOISE_MONO:   cfg_ff.noise_mono   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // A stage loads when it is empty or the stage after it moves on
   always_comb begin
      adv[pca_pkg::STAGES-1] = !valid_ff[pca_pkg::STAGES-1] || !rsp_stall;
      for (int k = pca_pkg::STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign valid_in = {valid_ff[pca_pkg::STAGES-2:0], req_valid};
   assign ctrl.adv = adv;

   // Stage valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < pca_pkg::STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[pca_pkg::STAGES-1];

   pca_hash u_hash (
      .clock      (clock),
      .ctrl       (ctrl),
      .pixel_x    (req_pixel_x),
      .pixel_y    (req_pixel_y),
      .noise_mono (cfg_ff.noise_mono),
      .hash_mix   (hash_mix)
   );

   pca_colour u_colour (
      .clock     (clock),
      .ctrl      (ctrl),
      .cfg       (cfg_ff),
      .red_in    (req_red_in),
      .green_in  (req_green_in),
      .blue_in   (req_blue_in),
      .alpha_in  (req_alpha_in),
      .hash_mix  (hash_mix),
      .red_out   (rsp_red_out),
      .green_out (rsp_green_out),
      .blue_out  (rsp_blue_out),
      .alpha_out (rsp_alpha_out)
   );

endmodule

@@ rtl/pca_checker.sv @@
// ----------------------------------------------------------------------------
// Pixel colour adjust: port checker
// Flow-control checks on the core's ports, attached by bind.
// ----------------------------------------------------------------------------
`include "pixel_colour_adjust_core_defines.svh"

module pca_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_blue_out,
   input logic [7:0] rsp_alpha_out
);

   // A held rsp beat keeps its payload
   `PCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_alpha_out), "rsp beat changed while stalled")

   // Reset empties the pipeline and opens the input
   `PCA_ASSERT_NEXT_RST(a_reset_empty, reset, !rsp_valid && !req_stall, "pipeline not empty after reset")

   // With the output register empty the input is never held off
   `PCA_ASSERT_IMP(a_no_false_stall, !rsp_valid, !req_stall, "req stalled with empty output")

   // A pending req beat blocked this cycle must see a full output
   `PCA_ASSERT_IMP(a_stall_needs_output, req_valid && req_stall, rsp_valid && rsp_stall, "req stalled without output back-pressure")

endmodule

bind pixel_colour_adjust_core pca_checker u_pca_checker (.*);
